### sv/modbus_memory_access_slave_top_defines.svh
// Assertion helpers for the memory access slave.
`ifndef MODBUS_MEMORY_ACCESS_SLAVE_TOP_DEFINES_SVH
`define MODBUS_MEMORY_ACCESS_SLAVE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MMAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define MMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mmas_pkg.sv
`timescale 1ns / 1ps
package mmas_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} rx_req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
	} tx_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RX_CRC,
		ST_CHECK,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FETCH,
		ST_EMIT,
		ST_TX_CRC
	} state_t;

	typedef enum logic [2:0] {
		PH_ADDR,
		PH_FN,
		PH_CODE,
		PH_COUNT,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  FN_WR_RAM   = 8'h41;
	localparam logic [7:0]  FN_WR_EEP   = 8'h43;
	localparam logic [7:0]  FN_RD_RAM   = 8'h44;
	localparam logic [7:0]  FN_RD_EEP   = 8'h46;
	localparam logic [7:0]  FN_EXC_FLAG = 8'h80;
	localparam logic [7:0]  EXC_NONE    = 8'h00;
	localparam logic [7:0]  EXC_ADDRESS = 8'h02;
	localparam logic [7:0]  EXC_VALUE   = 8'h03;
	localparam logic [7:0]  OWN_ADDR_RST    = 8'h68;
	localparam logic [7:0]  SECOND_ADDR_RST = 8'hFE;
	localparam int          HDR_BYTES   = 5;
	localparam int          MIN_FRAME   = 7;
	localparam int          MIN_WR_FRAME = 8;

	// Two bit steps of the reflected CRC shift register
	function automatic logic [15:0] crc_step2(input logic [15:0] c);
		logic [15:0] a;
		logic [15:0] b;
		a = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		b = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
		return b;
	endfunction

endpackage

### sv/modbus_memory_access_slave_top.sv
`timescale 1ns / 1ps
// Memory access slave for a Modbus-style serial link.
// Input channel (in_valid / in_stall / in_data) carries received frame bytes;
// frame_end marks the last byte. Each byte is accepted in IDLE and then runs
// through the shared CRC unit, which shifts two bits per cycle. in_stall
// stays high while a byte or a frame is being processed.
// At frame end the frame is checked (length, slave address, CRC, function,
// command length). A bad frame is dropped silently. A good one runs a RAM or
// EEPROM read or write and returns a response or exception on the output
// channel (out_valid / out_stall / out_data), CRC low then high byte, with
// tx_last on the high byte. Every header and data response byte passes through
// the same CRC unit. A write first copies each data byte from the frame buffer
// (COPY_RD, COPY_WR); a read fetches each data byte (FETCH). CRC bytes bypass the CRC unit.
// A stalled output holds its byte; the sequencer waits until the output
// register frees up. Configuration writes (cfg_we/cfg_index/cfg_wdata) are
// taken at any time but are meant for idle periods.
// After reset a clearing pass zeroes both stores, one entry per cycle across
// max(RAM_BYTES, EEPROM_BYTES) entries, with in_stall high.
module modbus_memory_access_slave_top #(
	parameter int FRAME_BYTES  = 64,
	parameter int RAM_BYTES    = 1024,
	parameter int EEPROM_BYTES = 1024,
	parameter int MAX_COUNT    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mmas_pkg::rx_req_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output mmas_pkg::tx_req_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_wdata
);
	import mmas_pkg::*;

	localparam int CNT_W = $clog2(FRAME_BYTES + 1);
	localparam int FAW   = $clog2(FRAME_BYTES);
	localparam int RAW   = $clog2(RAM_BYTES);
	localparam int EAW   = $clog2(EEPROM_BYTES);
	localparam int CLR_N = (RAM_BYTES > EEPROM_BYTES) ? RAM_BYTES : EEPROM_BYTES;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [16:0] RAM_LIM = 17'(RAM_BYTES);
	localparam logic [16:0] EEP_LIM = 17'(EEPROM_BYTES);
	localparam logic [7:0]  MAX_CNT = 8'(MAX_COUNT);

	state_t           state_q, state_d;
	phase_t           ph_q, ph_d;
	logic [7:0]       own_q, second_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [15:0]      crc_q;
	logic [1:0]       step_q;
	logic             end_q;
	logic [7:0]       hdr_q [HDR_BYTES];
	logic             exc_q, is_wr_q, is_ram_q;
	logic [7:0]       code_q;
	logic [7:0]       idx_q;
	logic [CLR_W-1:0] clr_q;
	logic             out_valid_q;
	tx_req_t          out_q;

	logic [7:0] frame_mem [FRAME_BYTES];
	logic [7:0] ram_mem   [RAM_BYTES];
	logic [7:0] eep_mem   [EEPROM_BYTES];
	logic [7:0] frame_rd_q, ram_rd_q, eep_rd_q;

	logic        in_acc, out_free, clr_done, data_last;
	logic [7:0]  fn, cnt8, code_d, emit_byte;
	logic        fn_ok, is_wr, is_rm, drop, len_ok;
	logic [16:0] end_sum, tgt;
	logic [FAW-1:0] frame_ra;
	logic        frame_we;
	logic        ram_we, eep_we;
	logic [RAW-1:0] ram_a;
	logic [EAW-1:0] eep_a;
	logic [7:0]  mem_wd;

	// Decode the buffered header
	always_comb begin
		fn      = hdr_q[1];
		cnt8    = hdr_q[4];
		fn_ok   = (fn == FN_WR_RAM) || (fn == FN_WR_EEP) ||
		          (fn == FN_RD_RAM) || (fn == FN_RD_EEP);
		is_wr   = (fn == FN_WR_RAM) || (fn == FN_WR_EEP);
		is_rm   = (fn == FN_WR_RAM) || (fn == FN_RD_RAM);
		drop    = ovf_q || (cnt_q < CNT_W'(MIN_FRAME)) ||
		          ((hdr_q[0] != own_q) && (hdr_q[0] != second_q)) ||
		          (crc_q != 16'h0000) || !fn_ok ||
		          (is_wr && (cnt_q < CNT_W'(MIN_WR_FRAME)));
		len_ok  = (9'(cnt_q) == (9'(MIN_FRAME) + 9'(cnt8)));
		end_sum = 17'({hdr_q[2], hdr_q[3]}) + 17'(cnt8);
		priority if ((cnt8 == 8'h00) || (cnt8 > MAX_CNT)) code_d = EXC_VALUE;
		else if (is_wr && !len_ok) code_d = EXC_VALUE;
		else if (end_sum > (is_rm ? RAM_LIM : EEP_LIM)) code_d = EXC_ADDRESS;
		else code_d = EXC_NONE;
		tgt       = 17'({hdr_q[2], hdr_q[3]}) + 17'(idx_q);
		frame_ra  = FAW'(9'(idx_q) + 9'(HDR_BYTES));
		data_last = ((9'(idx_q) + 9'd1) == 9'(cnt8));
	end

	// Select the next response byte
	always_comb begin
		unique case (ph_q)
			PH_ADDR:   emit_byte = hdr_q[0];
			PH_FN:     emit_byte = exc_q ? (fn | FN_EXC_FLAG) : fn;
			PH_CODE:   emit_byte = code_q;
			PH_COUNT:  emit_byte = cnt8;
			PH_DATA:   emit_byte = is_ram_q ? ram_rd_q : eep_rd_q;
			PH_CRC_LO: emit_byte = crc_q[7:0];
			PH_CRC_HI: emit_byte = crc_q[15:8];
			default:   emit_byte = crc_q[15:8];
		endcase
	end

	// Sequencer: next state and control
	always_comb begin
		state_d  = state_q;
		ph_d     = ph_q;
		in_stall = (state_q != ST_IDLE);
		in_acc   = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		clr_done = (clr_q == CLR_W'(CLR_N - 1));
		unique case (state_q)
			ST_CLEAR:   if (clr_done) state_d = ST_IDLE;
			ST_IDLE:    if (in_acc) state_d = ST_RX_CRC;
			ST_RX_CRC:  if (step_q == 2'd3) state_d = end_q ? ST_CHECK : ST_IDLE;
			ST_CHECK: begin
				ph_d = PH_ADDR;
				priority if (drop) state_d = ST_IDLE;
				else if (code_d != EXC_NONE) state_d = ST_EMIT;
				else if (is_wr) state_d = ST_COPY_RD;
				else state_d = ST_EMIT;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: state_d = data_last ? ST_EMIT : ST_COPY_RD;
			ST_FETCH:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					priority if (ph_q == PH_CRC_LO) begin
						ph_d = PH_CRC_HI;
					end else if (ph_q == PH_CRC_HI) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_TX_CRC;
					end
				end
			end
			ST_TX_CRC: begin
				if (step_q == 2'd3) begin
					state_d = ST_EMIT;
					unique case (ph_q)
						PH_ADDR: ph_d = PH_FN;
						PH_FN:   ph_d = exc_q ? PH_CODE : (is_wr_q ? PH_CRC_LO : PH_COUNT);
						PH_CODE: ph_d = PH_CRC_LO;
						PH_COUNT: begin
							ph_d    = PH_DATA;
							state_d = ST_FETCH;
						end
						PH_DATA: begin
							if (data_last) begin
								ph_d = PH_CRC_LO;
							end else begin
								state_d = ST_FETCH;
							end
						end
						default: ph_d = PH_CRC_LO;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory ports
	always_comb begin
		frame_we = in_acc && (cnt_q < CNT_W'(FRAME_BYTES));
		mem_wd   = (state_q == ST_CLEAR) ? 8'h00 : frame_rd_q;
		if (state_q == ST_CLEAR) begin
			ram_a  = clr_q[RAW-1:0];
			eep_a  = clr_q[EAW-1:0];
			ram_we = ({1'b0, clr_q} < (CLR_W + 1)'(RAM_BYTES));
			eep_we = ({1'b0, clr_q} < (CLR_W + 1)'(EEPROM_BYTES));
		end else begin
			ram_a  = tgt[RAW-1:0];
			eep_a  = tgt[EAW-1:0];
			ram_we = (state_q == ST_COPY_WR) && is_ram_q;
			eep_we = (state_q == ST_COPY_WR) && !is_ram_q;
		end
	end

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ph_q    <= PH_ADDR;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	// Advance control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= OWN_ADDR_RST;
			second_q    <= SECOND_ADDR_RST;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			crc_q       <= CRC_INIT;
			step_q      <= 2'd0;
			end_q       <= 1'b0;
			exc_q       <= 1'b0;
			is_wr_q     <= 1'b0;
			is_ram_q    <= 1'b0;
			code_q      <= EXC_NONE;
			idx_q       <= 8'd0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) second_q <= cfg_wdata;
				else own_q <= cfg_wdata;
			end
			if ((state_q == ST_EMIT) && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + CLR_W'(1);
				ST_IDLE: begin
					if (in_acc) begin
						if (cnt_q < CNT_W'(FRAME_BYTES)) cnt_q <= cnt_q + CNT_W'(1);
						else ovf_q <= 1'b1;
						crc_q  <= crc_q ^ {8'h00, in_data.rx_byte};
						step_q <= 2'd0;
						end_q  <= in_data.frame_end;
					end
				end
				ST_RX_CRC, ST_TX_CRC: begin
					crc_q  <= crc_step2(crc_q);
					step_q <= step_q + 2'd1;
					if ((state_q == ST_TX_CRC) && (step_q == 2'd3) &&
					    (ph_q == PH_DATA) && !data_last) idx_q <= idx_q + 8'd1;
				end
				ST_CHECK: begin
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					crc_q    <= CRC_INIT;
					exc_q    <= (code_d != EXC_NONE);
					code_q   <= code_d;
					is_wr_q  <= is_wr;
					is_ram_q <= is_rm;
					idx_q    <= 8'd0;
				end
				ST_COPY_WR: idx_q <= data_last ? 8'd0 : (idx_q + 8'd1);
				ST_EMIT: begin
					if (out_free) begin
						step_q      <= 2'd0;
						if (ph_q == PH_CRC_HI) crc_q <= CRC_INIT;
						else if (ph_q != PH_CRC_LO) crc_q <= crc_q ^ {8'h00, emit_byte};
					end
				end
				default: ;
			endcase
		end
	end

	// Capture header bytes and the output payload
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CNT_W'(HDR_BYTES))) hdr_q[cnt_q[2:0]] <= in_data.rx_byte;
		if ((state_q == ST_EMIT) && out_free) begin
			out_q.tx_byte <= emit_byte;
			out_q.tx_last <= (ph_q == PH_CRC_HI);
		end
	end

	// Frame buffer
	always_ff @(posedge clk) begin
		if (frame_we) frame_mem[cnt_q[FAW-1:0]] <= in_data.rx_byte;
		frame_rd_q <= frame_mem[frame_ra];
	end

	// RAM store
	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_a] <= mem_wd;
		ram_rd_q <= ram_mem[ram_a];
	end

	// EEPROM store
	always_ff @(posedge clk) begin
		if (eep_we) eep_mem[eep_a] <= mem_wd;
		eep_rd_q <= eep_mem[eep_a];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`include "modbus_memory_access_slave_top_defines.svh"

	`MMAS_ASSERT_NOW(a_clear_blocks_rx, state_q == ST_CLEAR, in_stall, "input taken during clear")
	`MMAS_ASSERT_NEXT(a_last_byte_out, (state_q == ST_EMIT) && (ph_q == PH_CRC_HI) && out_free, out_valid && out_data.tx_last && (state_q == ST_IDLE), "CRC high byte not presented")
	`MMAS_ASSERT_NEXT(a_mid_frame_back, (state_q == ST_RX_CRC) && (step_q == 2'd3) && !end_q, (state_q == ST_IDLE) && (cnt_q != '0), "mid-frame byte lost")

endmodule
